FILE: rtl/fpadr_pkg.sv
// Shared types and constants for the fixed-point ALU with decimal rounding.
// No dependencies; used by every module in rtl/.
`default_nettype none

package fpadr_pkg;

  localparam int unsigned WORD_BITS_DEF     = 32;
  localparam int unsigned DECIMAL_SCALE_DEF = 1000;

  // Fixed field widths of the item payloads and registers
  localparam int unsigned DATA_W        = 32;
  localparam int unsigned FRAC_DIGITS_W = 10;
  localparam int unsigned INT_BITS_W    = 6;
  localparam int unsigned FRAC_BITS_W   = 5;
  localparam int unsigned CFG_IDX_W     = 2;

  localparam logic [CFG_IDX_W-1:0] REG_INT_BITS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAC_BITS  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROUND_MODE = 2'd2;

  localparam logic [INT_BITS_W-1:0]  INT_BITS_RST  = 6'd16;
  localparam logic [FRAC_BITS_W-1:0] FRAC_BITS_RST = 5'd16;

  typedef enum logic [1:0] {
    CMD_PASS = 2'd0,
    CMD_ADD  = 2'd1,
    CMD_SUB  = 2'd2,
    CMD_MUL  = 2'd3
  } cmd_t;

  typedef struct packed {
    logic [1:0]        cmd;
    logic [DATA_W-1:0] operand_a;
    logic [DATA_W-1:0] operand_b;
  } in_item_t;

  typedef struct packed {
    logic [DATA_W-1:0]        result_word;
    logic                     is_negative;
    logic [DATA_W-1:0]        integer_magnitude;
    logic [FRAC_DIGITS_W-1:0] fraction_digits;
  } out_item_t;

  // Effective format after clamping: total width W, fraction bits B
  typedef struct packed {
    logic [INT_BITS_W-1:0]  w;
    logic [FRAC_BITS_W-1:0] b;
    logic                   round_up;
  } fmt_t;

endpackage

`default_nettype wire

FILE: rtl/fixed_point_alu_decimal_rounding_core.sv
// Top level of the fixed-point ALU with decimal rounding: config registers,
// format clamping, and the two pipeline halves. Depends on fpadr_pkg,
// fpadr_arith and fpadr_decimal.
`default_nettype none

// Takes one item per clock (pass, add, subtract or multiply on two signed
// Q(A.B) words) and returns the wrapped raw result plus a sign, integer
// magnitude and decimal fraction rounded toward zero or plus infinity. The
// pipeline has four register stages; throughput is one item per cycle while
// res_stall is low, and the stage depth is set by the WORD_BITS x WORD_BITS
// signed multiplier in stage one. res_stall backs up through every stage to
// op_stall; no item is dropped or repeated. Write int_bits, frac_bits and
// round_mode only while no item is in flight.
module fixed_point_alu_decimal_rounding_core #(
  parameter int unsigned WORD_BITS     = fpadr_pkg::WORD_BITS_DEF,
  parameter int unsigned DECIMAL_SCALE = fpadr_pkg::DECIMAL_SCALE_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [fpadr_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [fpadr_pkg::INT_BITS_W-1:0]     cfg_data,
  input  logic                                 op_valid,
  output logic                                 op_stall,
  input  fpadr_pkg::in_item_t                  op,
  output logic                                 res_valid,
  input  logic                                 res_stall,
  output fpadr_pkg::out_item_t                 res
);
  import fpadr_pkg::*;

  logic [INT_BITS_W-1:0]  int_bits;
  logic [FRAC_BITS_W-1:0] frac_bits;
  logic                   round_mode;

  logic [FRAC_BITS_W-1:0] b_eff;
  logic [INT_BITS_W-1:0]  a_eff;
  logic [INT_BITS_W:0]    w_sum;
  fmt_t                   fmt;

  logic                 mid_valid, mid_stall, mid_neg;
  logic [WORD_BITS-1:0] mid_word, mid_mag;

  always_ff @(posedge clk) begin
    if (rst) begin
      int_bits   <= INT_BITS_RST;
      frac_bits  <= FRAC_BITS_RST;
      round_mode <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_INT_BITS:   int_bits   <= cfg_data;
        REG_FRAC_BITS:  frac_bits  <= cfg_data[FRAC_BITS_W-1:0];
        REG_ROUND_MODE: round_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Clamp B to WORD_BITS-1, A to at least 1, and A+B to the word width
  always_comb begin
    b_eff = (frac_bits > FRAC_BITS_W'(WORD_BITS - 1)) ? FRAC_BITS_W'(WORD_BITS - 1)
                                                     : frac_bits;
    a_eff = (int_bits == '0) ? INT_BITS_W'(1) : int_bits;
    w_sum = (INT_BITS_W + 1)'(a_eff) + (INT_BITS_W + 1)'(b_eff);
    fmt.w = (w_sum > (INT_BITS_W + 1)'(WORD_BITS)) ? INT_BITS_W'(WORD_BITS)
                                                   : INT_BITS_W'(w_sum);
    fmt.b        = b_eff;
    fmt.round_up = round_mode;
  end

  fpadr_arith #(
    .WORD_BITS (WORD_BITS)
  ) u_arith (
    .clk       (clk),
    .rst       (rst),
    .fmt       (fmt),
    .in_valid  (op_valid),
    .in_stall  (op_stall),
    .in_item   (op),
    .out_valid (mid_valid),
    .out_stall (mid_stall),
    .out_word  (mid_word),
    .out_mag   (mid_mag),
    .out_neg   (mid_neg)
  );

  fpadr_decimal #(
    .WORD_BITS     (WORD_BITS),
    .DECIMAL_SCALE (DECIMAL_SCALE)
  ) u_decimal (
    .clk       (clk),
    .rst       (rst),
    .fmt       (fmt),
    .in_valid  (mid_valid),
    .in_stall  (mid_stall),
    .in_word   (mid_word),
    .in_mag    (mid_mag),
    .in_neg    (mid_neg),
    .out_valid (res_valid),
    .out_stall (res_stall),
    .out_item  (res)
  );

  // A negative result never rounds to zero magnitude
  a_neg_nonzero: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.is_negative |->
      (res.integer_magnitude != '0) || (res.fraction_digits != '0))
    else $error("negative zero on output");

  // A negative decimal value comes from a nonzero raw word
  a_neg_word: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.is_negative |-> res.result_word != '0)
    else $error("negative result with zero raw word");

  // Decimal fraction stays below one step after carry
  a_frac_range: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> res.fraction_digits < FRAC_DIGITS_W'(DECIMAL_SCALE))
    else $error("fraction digits out of range");

endmodule

`default_nettype wire

FILE: rtl/fpadr_arith.sv
// Stages 1-2: sign extension, add/sub/multiply, product shift, wrap and abs.
// Depends on fpadr_pkg.
`default_nettype none

module fpadr_arith #(
  parameter int unsigned WORD_BITS = fpadr_pkg::WORD_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  fpadr_pkg::fmt_t       fmt,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  fpadr_pkg::in_item_t   in_item,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [WORD_BITS-1:0]  out_word,
  output logic [WORD_BITS-1:0]  out_mag,
  output logic                  out_neg
);
  import fpadr_pkg::*;

  localparam int unsigned PW = 2 * WORD_BITS;
  localparam int unsigned IW = (WORD_BITS > 1) ? $clog2(WORD_BITS) : 1;

  logic adv1, adv2;
  logic v1, v2;

  logic [INT_BITS_W-1:0]       sh;
  logic [WORD_BITS-1:0]        ones;
  logic [WORD_BITS-1:0]        mask_w;
  logic signed [WORD_BITS-1:0] a_up, b_up, xs, ys, lin;
  logic signed [PW-1:0]        prod;

  // stage 1 registers
  logic [1:0]                  s1_cmd;
  logic signed [WORD_BITS-1:0] s1_lin;
  logic signed [PW-1:0]        s1_prod;

  logic [WORD_BITS-1:0] r, word, mag;
  logic                 neg;

  assign adv2     = !v2 || !out_stall;
  assign adv1     = !v1 || adv2;
  assign in_stall = !adv1;

  assign sh     = INT_BITS_W'(WORD_BITS) - fmt.w;
  assign ones   = '1;
  assign mask_w = ones >> sh;

  always_comb begin
    a_up = in_item.operand_a[WORD_BITS-1:0] << sh;
    b_up = in_item.operand_b[WORD_BITS-1:0] << sh;
    xs   = a_up >>> sh;
    ys   = b_up >>> sh;
    prod = PW'(xs) * PW'(ys);
    unique case (in_item.cmd)
      CMD_ADD: lin = xs + ys;
      CMD_SUB: lin = xs - ys;
      default: lin = xs;
    endcase
  end

  // Floor shift of the product is an arithmetic shift; wrapping to W bits
  // happens after the low WORD_BITS are taken.
  always_comb begin
    if (s1_cmd == CMD_MUL) begin
      r = WORD_BITS'(s1_prod >>> fmt.b);
    end else begin
      r = s1_lin;
    end
    word = r & mask_w;
    neg  = word[IW'(fmt.w - INT_BITS_W'(1))];
    mag  = neg ? ((WORD_BITS'(0) - word) & mask_w) : word;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      if (adv1) v1 <= in_valid;
      if (adv2) v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1 && in_valid) begin
      s1_cmd  <= in_item.cmd;
      s1_lin  <= lin;
      s1_prod <= prod;
    end
    if (adv2 && v1) begin
      out_word <= word;
      out_mag  <= mag;
      out_neg  <= neg;
    end
  end

  assign out_valid = v2;

endmodule

`default_nettype wire

FILE: rtl/fpadr_decimal.sv
// Stages 3-4: split magnitude into integer and fraction, scale the fraction
// to decimal units, round and carry. Depends on fpadr_pkg.
`default_nettype none

module fpadr_decimal #(
  parameter int unsigned WORD_BITS     = fpadr_pkg::WORD_BITS_DEF,
  parameter int unsigned DECIMAL_SCALE = fpadr_pkg::DECIMAL_SCALE_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  fpadr_pkg::fmt_t      fmt,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [WORD_BITS-1:0] in_word,
  input  logic [WORD_BITS-1:0] in_mag,
  input  logic                 in_neg,
  output logic                 out_valid,
  input  logic                 out_stall,
  output fpadr_pkg::out_item_t out_item
);
  import fpadr_pkg::*;

  localparam int unsigned SB = $clog2(DECIMAL_SCALE);
  localparam int unsigned TB = $clog2(DECIMAL_SCALE + 1);
  localparam int unsigned FW = WORD_BITS + TB;

  logic adv3, adv4;
  logic v3, v4;

  logic [WORD_BITS-1:0] mask_b, ip, f;
  logic [FW-1:0]        fs;

  logic [WORD_BITS-1:0] s3_word, s3_ip;
  logic [FW-1:0]        s3_fs;
  logic                 s3_neg;

  logic [FW:0]          rnd, sum, t;
  logic                 carry;
  logic [WORD_BITS-1:0] int_mag;
  logic [SB-1:0]        frac;
  out_item_t            res;

  assign adv4     = !v4 || !out_stall;
  assign adv3     = !v3 || adv4;
  assign in_stall = !adv3;

  assign mask_b = (WORD_BITS'(1) << fmt.b) - WORD_BITS'(1);

  always_comb begin
    ip = in_mag >> fmt.b;
    f  = in_mag & mask_b;
    fs = FW'(f) * FW'(DECIMAL_SCALE);
  end

  // Round-up adds 2^B-1 before the shift for non-negative values only; a full step carries into the integer.
  always_comb begin
    rnd      = (fmt.round_up && !s3_neg) ? (FW + 1)'(mask_b) : '0;
    sum      = (FW + 1)'(s3_fs) + rnd;
    t        = sum >> fmt.b;
    carry    = (t == (FW + 1)'(DECIMAL_SCALE));
    int_mag  = carry ? (s3_ip + WORD_BITS'(1)) : s3_ip;
    frac     = carry ? '0 : t[SB-1:0];
    res.result_word       = DATA_W'(s3_word);
    res.is_negative       = s3_neg && ((int_mag != '0) || (frac != '0));
    res.integer_magnitude = DATA_W'(int_mag);
    res.fraction_digits   = FRAC_DIGITS_W'(frac);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (adv3) v3 <= in_valid;
      if (adv4) v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (adv3 && in_valid) begin
      s3_word <= in_word;
      s3_ip   <= ip;
      s3_fs   <= fs;
      s3_neg  <= in_neg;
    end
    if (adv4 && v3) begin
      out_item <= res;
    end
  end

  assign out_valid = v4;

endmodule

`default_nettype wire

FILE: sim/fixed_point_alu_decimal_rounding_core_checker.sv
// Result checker for the fixed-point ALU with decimal rounding: watches the op
// and result channels and the register writes, predicts each result, compares.
// Depends on fpadr_pkg.

module fixed_point_alu_decimal_rounding_core_checker
  import fpadr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [INT_BITS_W-1:0] cfg_data,
  input  logic                  op_valid,
  input  logic                  op_stall,
  input  in_item_t              op,
  input  logic                  res_valid,
  input  logic                  res_stall,
  input  out_item_t             res,
  output int                    mismatch_count,
  output int                    results_owed
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [INT_BITS_W-1:0]  int_bits_q;
  logic [FRAC_BITS_W-1:0] frac_bits_q;
  logic                   round_up_q;
  out_item_t              owed_results[$];

  initial begin
    mismatch_count = 0;
    results_owed   = 0;
  end

  function automatic logic signed [63:0] sext_word(input logic [63:0] u, input int unsigned w);
    logic [63:0] m;
    m = u & ((64'd1 << w) - 64'd1);
    if (m[w-1]) return $signed(m) - $signed(64'd1 << w);
    return $signed(m);
  endfunction

  // Expected result of one item under the current format and rounding mode
  function automatic out_item_t decimal_of(input in_item_t it);
    int unsigned      fb, ib, wb;
    logic signed [63:0] x, y, r, v;
    logic [63:0]      word, mag, scaled, m, q, f, bmask;
    logic             neg;
    out_item_t        o;
    fb = 32'(frac_bits_q);
    if (fb > WORD_BITS_DEF - 1) fb = WORD_BITS_DEF - 1;
    ib = 32'(int_bits_q);
    if (ib < 1) ib = 1;
    if (ib + fb > WORD_BITS_DEF) ib = WORD_BITS_DEF - fb;
    wb = ib + fb;
    bmask = (64'd1 << fb) - 64'd1;
    x = sext_word({32'd0, it.operand_a}, wb);
    y = sext_word({32'd0, it.operand_b}, wb);
    case (it.cmd)
      CMD_PASS: r = x;
      CMD_ADD:  r = x + y;
      CMD_SUB:  r = x - y;
      default:  r = (x * y) >>> fb;
    endcase
    word = r & ((64'd1 << wb) - 64'd1);
    v = sext_word(word, wb);
    neg = (v < 0);
    mag = neg ? -v : v;
    scaled = mag * 64'd1000;
    // plus-infinity rounding only lifts positive values; negatives truncate
    if (round_up_q && !neg) m = (scaled + bmask) >> fb;
    else m = scaled >> fb;
    q = m / 64'd1000;
    f = m % 64'd1000;
    o.result_word       = word[31:0];
    o.is_negative       = neg && (m != 64'd0);
    o.integer_magnitude = q[31:0];
    o.fraction_digits   = f[9:0];
    return o;
  endfunction

  task automatic flag_mismatch(input string what, input logic [63:0] got,
                               input logic [63:0] want);
    $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    out_item_t e;
    if (rst) begin
      int_bits_q  = INT_BITS_RST;
      frac_bits_q = FRAC_BITS_RST;
      round_up_q  = 1'b0;
      owed_results.delete();
    end else begin
      if (op_valid && !op_stall) owed_results.push_back(decimal_of(op));
      if (res_valid && !res_stall) begin
        if (owed_results.size() == 0) begin
          flag_mismatch("result item with nothing owed", 64'(res.result_word), 64'd0);
        end else begin
          e = owed_results.pop_front();
          if (res.result_word !== e.result_word)
            flag_mismatch("result_word", 64'(res.result_word), 64'(e.result_word));
          if (res.is_negative !== e.is_negative)
            flag_mismatch("is_negative", 64'(res.is_negative), 64'(e.is_negative));
          if (res.integer_magnitude !== e.integer_magnitude)
            flag_mismatch("integer_magnitude", 64'(res.integer_magnitude),
                          64'(e.integer_magnitude));
          if (res.fraction_digits !== e.fraction_digits)
            flag_mismatch("fraction_digits", 64'(res.fraction_digits),
                          64'(e.fraction_digits));
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_INT_BITS:   int_bits_q  = cfg_data;
          REG_FRAC_BITS:  frac_bits_q = cfg_data[FRAC_BITS_W-1:0];
          REG_ROUND_MODE: round_up_q  = cfg_data[0];
          default: ;
        endcase
      end
    end
    results_owed = owed_results.size();
  end

endmodule

FILE: sim/fixed_point_alu_decimal_rounding_core_test.sv
// Top of the fixed-point ALU test: clock, reset, register writes, op stimulus
// and result stall pattern; the checker module does all comparison.
// Depends on fpadr_pkg, the core and fixed_point_alu_decimal_rounding_core_checker.

module fixed_point_alu_decimal_rounding_core_test;
  timeunit 1ns;
  timeprecision 1ps;
  import fpadr_pkg::*;

  // register index that maps to no register
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 2'd3;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [INT_BITS_W-1:0] cfg_data;
  logic                  op_valid;
  logic                  op_stall;
  in_item_t              op;
  logic                  res_valid;
  logic                  res_stall;
  out_item_t             res;
  int                    mismatch_count;
  int                    results_owed;
  bit                    long_hold_req;

  fixed_point_alu_decimal_rounding_core dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .op_valid(op_valid), .op_stall(op_stall), .op(op),
    .res_valid(res_valid), .res_stall(res_stall), .res(res)
  );

  fixed_point_alu_decimal_rounding_core_checker chk (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .op_valid(op_valid), .op_stall(op_stall), .op(op),
    .res_valid(res_valid), .res_stall(res_stall), .res(res),
    .mismatch_count(mismatch_count), .results_owed(results_owed)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("FAIL fixed_point_alu_decimal_rounding_core");
    $finish;
  end

  // Receiver: stall segments of random density, plus one long hold on request;
  // a request cuts the running segment short so the hold starts at once
  initial begin
    int unsigned mode, len;
    res_stall = 1'b0;
    long_hold_req = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (long_hold_req) begin
        res_stall <= 1'b1;
        repeat (300) @(negedge clk);
        long_hold_req = 1'b0;
      end else begin
        mode = $urandom_range(0, 3);
        len  = $urandom_range(8, 120);
        for (int unsigned k = 0; k < len && !long_hold_req; k++) begin
          case (mode)
            0:       res_stall <= 1'b0;
            1:       res_stall <= ($urandom_range(0, 3) == 0);
            2:       res_stall <= 1'($urandom_range(0, 1));
            default: res_stall <= ($urandom_range(0, 3) != 0);
          endcase
          @(negedge clk);
        end
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance
  task automatic drive_item(input logic [1:0] cmd, input logic [31:0] a,
                            input logic [31:0] b);
    op_valid     <= 1'b1;
    op.cmd       <= cmd;
    op.operand_a <= a;
    op.operand_b <= b;
    @(posedge clk);
    while (op_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [INT_BITS_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // Sender stops, every owed result comes back, then the pipe settles
  task automatic drain_pipeline();
    op_valid <= 1'b0;
    @(negedge clk);
    while (results_owed != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic set_format(input logic [5:0] ib, input logic [5:0] fb, input logic rm);
    drain_pipeline();
    write_reg(REG_INT_BITS, ib);
    write_reg(REG_FRAC_BITS, fb);
    write_reg(REG_ROUND_MODE, {5'd0, rm});
  endtask

  // Operands biased toward width boundaries at any format
  function automatic logic [31:0] pick_operand();
    logic [31:0]  v, lowm;
    int unsigned  k;
    k = $urandom_range(0, 31);
    lowm = (32'd1 << k) - 32'd1;
    case ($urandom_range(0, 6))
      0, 1:    v = $urandom();
      2:       v = lowm | ($urandom() & ~lowm & {32{$urandom_range(0, 1) == 1}});
      3:       v = 32'd1 << k;
      4:       v = ~lowm;
      5: begin
        v = $urandom_range(0, 255);
        if ($urandom_range(0, 1)) v = -v;
      end
      default: v = ($urandom() & lowm) | ($urandom_range(0, 1) ? ~lowm : 32'd0);
    endcase
    return v;
  endfunction

  task automatic random_phase(input int count);
    int burst_left, gap;
    burst_left = 0;
    for (int i = 0; i < count; i++) begin
      if (burst_left == 0) begin
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        if (gap > 0) begin
          op_valid <= 1'b0;
          repeat (gap) @(negedge clk);
        end
        burst_left = $urandom_range(1, 24);
      end
      drive_item(2'($urandom_range(0, 3)), pick_operand(), pick_operand());
      burst_left--;
    end
  endtask

  initial begin
    logic [5:0] ib, fb;
    rst       = 1'b1;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    op_valid  = 1'b0;
    op        = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Q16.16, truncation: extremes, negative zero, wrap, floor on multiply
    set_format(6'd16, 6'd16, 1'b0);
    drive_item(CMD_PASS, 32'h0000_0000, 32'h1234_5678);
    drive_item(CMD_PASS, 32'h7FFF_FFFF, 32'h0000_0000);
    drive_item(CMD_PASS, 32'h8000_0000, 32'hFFFF_FFFF);
    drive_item(CMD_PASS, 32'hFFFF_FFFF, 32'h0000_0000);
    drive_item(CMD_ADD,  32'h7FFF_FFFF, 32'h0000_0001);
    drive_item(CMD_SUB,  32'h8000_0000, 32'h0000_0001);
    drive_item(CMD_SUB,  32'h0001_8000, 32'h0003_0000);
    drive_item(CMD_MUL,  32'h0002_0000, 32'h0003_0000);
    drive_item(CMD_MUL,  32'hFFFE_8000, 32'h0002_0000);
    drive_item(CMD_MUL,  32'hFFFF_FFFF, 32'h0000_8000);
    drive_item(CMD_MUL,  32'h7FFF_FFFF, 32'h7FFF_FFFF);

    // round up: tiny positive lifts, small negative becomes plain zero
    set_format(6'd16, 6'd16, 1'b1);
    drive_item(CMD_PASS, 32'h0000_0001, 32'h0000_0000);
    drive_item(CMD_PASS, 32'hFFFF_FFFF, 32'h0000_0000);
    drive_item(CMD_PASS, 32'hFFFF_8000, 32'h0000_0000);
    drive_item(CMD_MUL,  32'h0001_0001, 32'h0001_0001);

    // zero integer bits act as one: a single-bit word
    set_format(6'd0, 6'd0, 1'b0);
    drive_item(CMD_PASS, 32'h0000_0001, 32'h0000_0000);
    drive_item(CMD_PASS, 32'hFFFF_FFFE, 32'hFFFF_FFFF);
    drive_item(CMD_ADD,  32'h0000_0001, 32'h0000_0001);
    drive_item(CMD_MUL,  32'hFFFF_FFFF, 32'h0000_0001);

    // word too wide: A shrinks to fit, widest fraction
    set_format(6'd63, 6'd31, 1'b1);
    drive_item(CMD_PASS, 32'h4000_0000, 32'h0000_0000);
    drive_item(CMD_PASS, 32'hC000_0000, 32'h0000_0000);
    drive_item(CMD_MUL,  32'h4000_0000, 32'h4000_0000);

    // integer only; a write to an unmapped index changes nothing
    set_format(6'd32, 6'd0, 1'b1);
    write_reg(REG_UNMAPPED, 6'h3F);
    drive_item(CMD_PASS, 32'h8000_0000, 32'h0000_0000);
    drive_item(CMD_MUL,  32'hFFFF_FFFF, 32'hFFFF_FFFF);

    for (int p = 0; p < 14; p++) begin
      case (p)
        0: set_format(6'd63, 6'd31, 1'b0);
        1: set_format(6'd0, 6'd0, 1'b1);
        2: set_format(6'd1, 6'd31, 1'b0);
        3: set_format(6'd32, 6'd0, 1'b0);
        4: set_format(6'd16, 6'd16, 1'b1);
        default: begin
          fb = 6'($urandom_range(0, 31));
          if ($urandom_range(0, 1)) ib = 6'($urandom_range(0, 63));
          else ib = 6'($urandom_range(1, 32 - fb));
          set_format(ib, fb, 1'($urandom_range(0, 1)));
        end
      endcase
      // receiver backs up for a long stretch while ops keep coming
      if (p == 4) long_hold_req = 1'b1;
      random_phase($urandom_range(100, 140));
    end

    drain_pipeline();
    repeat (20) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("PASS fixed_point_alu_decimal_rounding_core");
    end else begin
      $display("FAIL fixed_point_alu_decimal_rounding_core");
    end
    $finish;
  end

endmodule
